// ----- rtl/alfd_pkg.sv -----
// ----------------------------------------------------------------------------
// alfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package alfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd99;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 2'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_subsystem;
    logic [BYTE_W-1:0] frame_command;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W-1:0]  byte_position;
    logic [BYTE_W-1:0] data_byte;
    logic              has_payload;
    logic              frame_end;
  } frame_result_t;

endpackage

`default_nettype wire

// ----- rtl/alfd_if.sv -----
// ----------------------------------------------------------------------------
// alfd_if
// Valid/ready channels of the deframer: received bytes, frame words, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface alfd_byte_if;
  import alfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface alfd_frame_if;
  import alfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_subsystem;
  logic [BYTE_W-1:0] frame_command;
  logic [LEN_W-1:0]  payload_length;
  logic [LEN_W-1:0]  byte_position;
  logic [BYTE_W-1:0] data_byte;
  logic              has_payload;
  logic              frame_end;
  modport source (output valid, output frame_subsystem, output frame_command,
                  output payload_length, output byte_position, output data_byte,
                  output has_payload, output frame_end, input ready);
  modport sink   (input valid, input frame_subsystem, input frame_command,
                  input payload_length, input byte_position, input data_byte,
                  input has_payload, input frame_end, output ready);
endinterface

interface alfd_cfg_if;
  import alfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/alfd_parser.sv -----
// ----------------------------------------------------------------------------
// alfd_parser
// Frame state machine: header capture, length decode, payload word build.
// ----------------------------------------------------------------------------
`default_nettype none

module alfd_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [alfd_pkg::BYTE_W-1:0] rx_byte,
  input  logic [alfd_pkg::BYTE_W-1:0] start_marker,
  input  logic [alfd_pkg::LEN_W-1:0]  max_payload_length,
  output logic                        res_valid,
  output alfd_pkg::frame_result_t     res
);
  import alfd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_SUBSYS, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_DATA
  } phase_t;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  held_subsystem, held_subsystem_next;
  logic [BYTE_W-1:0]  held_command, held_command_next;
  logic [DIGIT_W-1:0] tens_digit, tens_digit_next;
  logic [LEN_W-1:0]   held_length, held_length_next;
  logic [LEN_W-1:0]   received_count, received_count_next;

  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   count_inc;

  assign is_digit  = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
  assign digit     = DIGIT_W'(rx_byte - DIGIT_ZERO);
  // tens * 10 = tens * 8 + tens * 2
  assign len       = {tens_digit, 3'b000} + {2'b00, tens_digit, 1'b0}
                   + {3'b000, digit};
  assign count_inc = received_count + LEN_W'(1);

  always_comb begin
    phase_next          = phase;
    held_subsystem_next = held_subsystem;
    held_command_next   = held_command;
    tens_digit_next     = tens_digit;
    held_length_next    = held_length;
    received_count_next = received_count;
    res_valid           = 1'b0;
    res                 = '0;
    res.frame_subsystem = held_subsystem;
    res.frame_command   = held_command;
    res.payload_length  = held_length;

    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == start_marker) begin
          phase_next          = PH_SUBSYS;
          held_subsystem_next = '0;
          held_command_next   = '0;
          tens_digit_next     = '0;
          held_length_next    = '0;
          received_count_next = '0;
        end
      end
      PH_SUBSYS: begin
        held_subsystem_next = rx_byte;
        phase_next          = PH_CMD;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        phase_next        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (is_digit) begin
          tens_digit_next = digit;
          phase_next      = PH_LEN_LO;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_LEN_LO: begin
        phase_next = PH_IDLE;
        if (is_digit && (tens_digit <= DIGIT_W'(9)) && (len <= max_payload_length)) begin
          if (len == '0) begin
            // empty frame: one word with no payload
            res_valid          = 1'b1;
            res.payload_length = '0;
            res.frame_end      = 1'b1;
          end else begin
            held_length_next    = len;
            received_count_next = '0;
            phase_next          = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_valid           = 1'b1;
        res.byte_position   = received_count;
        res.data_byte       = rx_byte;
        res.has_payload     = 1'b1;
        received_count_next = count_inc;
        if (count_inc >= held_length) begin
          res.frame_end = 1'b1;
          phase_next    = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    // leaving a frame clears the held context
    if (phase != PH_IDLE && phase_next == PH_IDLE) begin
      held_subsystem_next = '0;
      held_command_next   = '0;
      tens_digit_next     = '0;
      held_length_next    = '0;
      received_count_next = '0;
    end
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      held_subsystem <= '0;
      held_command   <= '0;
      tens_digit     <= '0;
      held_length    <= '0;
      received_count <= '0;
    end else if (step) begin
      phase          <= phase_next;
      held_subsystem <= held_subsystem_next;
      held_command   <= held_command_next;
      tens_digit     <= tens_digit_next;
      held_length    <= held_length_next;
      received_count <= received_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/alfd_out_reg.sv -----
// ----------------------------------------------------------------------------
// alfd_out_reg
// Result register that drives the frame word channel.
// ----------------------------------------------------------------------------
`default_nettype none

module alfd_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  alfd_pkg::frame_result_t res,
  output logic                    can_load,
  alfd_frame_if.source            frame
);
  import alfd_pkg::*;

  logic          valid;
  frame_result_t word;

  // free when empty or when the held word leaves this cycle
  assign can_load = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      word <= res;
    end
  end

  assign frame.valid           = valid;
  assign frame.frame_subsystem = word.frame_subsystem;
  assign frame.frame_command   = word.frame_command;
  assign frame.payload_length  = word.payload_length;
  assign frame.byte_position   = word.byte_position;
  assign frame.data_byte       = word.data_byte;
  assign frame.has_payload     = word.has_payload;
  assign frame.frame_end       = word.frame_end;

endmodule

`default_nettype wire

// ----- rtl/ascii_length_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// ascii_length_frame_deframer
// Hunts a byte stream for start-marked, ASCII-length-prefixed frames.
// ----------------------------------------------------------------------------
// Output: a payload word appears on frame in the cycle after its byte is taken.
// Throughput: one byte per cycle; rx stalls only while the output register
//   holds a word that frame does not take.
// Reset (rst, synchronous): parser back to hunting, output register empty,
//   start_marker = 0, max_payload_length = 99.
`default_nettype none

module ascii_length_frame_deframer (
  input  logic          clk,
  input  logic          rst,
  alfd_byte_if.sink     rx,
  alfd_frame_if.source  frame,
  alfd_cfg_if.sink      cfg
);
  import alfd_pkg::*;

  // Configuration registers, live at once
  logic [BYTE_W-1:0] start_marker;
  logic [LEN_W-1:0]  max_payload_length;

  logic              step;
  logic              can_load;
  logic              res_valid;
  frame_result_t     res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker       <= '0;
      max_payload_length <= MAX_LEN_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_START_MARKER) begin
        start_marker <= cfg.data;
      end else if (cfg.index == REG_MAX_LENGTH) begin
        max_payload_length <= cfg.data[LEN_W-1:0];
      end
    end
  end

  // A byte is taken whenever the output register can take its word (if any).
  assign rx.ready = can_load;
  assign step     = rx.valid && can_load;

  alfd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .rx_byte            (rx.rx_byte),
    .start_marker       (start_marker),
    .max_payload_length (max_payload_length),
    .res_valid          (res_valid),
    .res                (res)
  );

  // Word register between parser and frame channel
  alfd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .frame    (frame)
  );

endmodule

`default_nettype wire

// ----- tb/ascii_length_frame_deframer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_length_frame_deframer_tb
// Drives received bytes into the deframer under random gaps and back
// pressure, tracks the frame parser in a local model and checks every
// frame word it emits, across several start-marker / max-length settings.
// ----------------------------------------------------------------------------

module ascii_length_frame_deframer_tb;
  import alfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // idle cycles before giving up
  localparam int HOLDOFF_CYCLES = 400;   // long frame-side stall
  localparam int PHASE_BYTES    = 260;   // random bytes per setting
  localparam int NUM_PHASES     = 6;

  // Parser phases, mirrored from the block's frame layout
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SUBSYS = 3'd1,
    PH_CMD    = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_DATA   = 3'd5
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst;

  alfd_byte_if  rx_if ();
  alfd_frame_if frame_if ();
  alfd_cfg_if   cfg_if ();

  ascii_length_frame_deframer u_dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_if.sink),
    .frame (frame_if.source),
    .cfg   (cfg_if.sink)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Local copy of the parser: registers, frame state, pending words
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]  cur_marker;
  logic [LEN_W-1:0]   cur_max_len;

  parse_phase_t       hunt_phase;
  logic [BYTE_W-1:0]  hdr_subsys;
  logic [BYTE_W-1:0]  hdr_cmd;
  logic [DIGIT_W-1:0] len_tens;
  logic [LEN_W-1:0]   frame_len;
  logic [LEN_W-1:0]   bytes_seen;

  frame_result_t      expected_words[$];
  logic [BYTE_W-1:0]  byte_q[$];

  int  errors = 0;
  int  tx_idle_pct;
  int  rx_stall_pct;
  logic holdoff_kick;
  int  holdoff_left;
  int  idle_cycles;

  // Any drop or finished frame wipes the held header and counters
  function automatic void clear_frame();
    hunt_phase = PH_IDLE;
    hdr_subsys = '0;
    hdr_cmd    = '0;
    len_tens   = '0;
    frame_len  = '0;
    bytes_seen = '0;
  endfunction

  function automatic bit is_digit(input logic [BYTE_W-1:0] b);
    return (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
  endfunction

  // Advance the parser by one received byte; returns 1 when a word is due
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                      output frame_result_t word);
    int lenv;
    word = '0;
    deframe_byte = 1'b0;
    case (hunt_phase)
      PH_IDLE: begin
        if (b == cur_marker) begin
          clear_frame();
          hunt_phase = PH_SUBSYS;
        end
      end
      PH_SUBSYS: begin
        hdr_subsys = b;
        hunt_phase = PH_CMD;
      end
      PH_CMD: begin
        hdr_cmd    = b;
        hunt_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        // bad digit kills the frame; the byte is not rechecked as a start
        if (!is_digit(b)) begin
          clear_frame();
        end else begin
          len_tens   = DIGIT_W'(b - DIGIT_ZERO);
          hunt_phase = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        if (!is_digit(b) || len_tens > 9) begin
          clear_frame();
        end else begin
          lenv = int'(len_tens) * 10 + int'(b - DIGIT_ZERO);
          if (lenv > int'(cur_max_len)) begin
            clear_frame();
          end else begin
            frame_len  = LEN_W'(lenv);
            bytes_seen = '0;
            if (lenv == 0) begin
              // empty frame: a single word with no data, marked last
              word.frame_subsystem = hdr_subsys;
              word.frame_command   = hdr_cmd;
              word.frame_end       = 1'b1;
              deframe_byte         = 1'b1;
              clear_frame();
            end else begin
              hunt_phase = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        word.frame_subsystem = hdr_subsys;
        word.frame_command   = hdr_cmd;
        word.payload_length  = frame_len;
        word.byte_position   = bytes_seen;
        word.data_byte       = b;
        word.has_payload     = 1'b1;
        deframe_byte         = 1'b1;
        bytes_seen           = bytes_seen + 1'b1;
        if (bytes_seen >= frame_len) begin
          word.frame_end = 1'b1;
          clear_frame();
        end
      end
      default: clear_frame();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver: takes the next byte from byte_q, random gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rx_driver
    frame_result_t word;
    if (rst) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      clear_frame();
    end else begin
      // a byte is taken at this edge: advance the model
      if (rx_if.valid && rx_if.ready) begin
        if (deframe_byte(rx_if.rx_byte, word))
          expected_words.push_back(word);
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= byte_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame monitor: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : frame_monitor
    frame_result_t want;
    if (rst) begin
      frame_if.ready <= 1'b0;
      holdoff_left   <= 0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word expected none actual %h", $time,
                   {frame_if.frame_subsystem, frame_if.frame_command,
                    frame_if.payload_length, frame_if.byte_position,
                    frame_if.data_byte, frame_if.has_payload, frame_if.frame_end});
        end else begin
          want = expected_words.pop_front();
          check_field("frame_subsystem", want.frame_subsystem, frame_if.frame_subsystem);
          check_field("frame_command", want.frame_command, frame_if.frame_command);
          check_field("payload_length", want.payload_length, frame_if.payload_length);
          check_field("byte_position", want.byte_position, frame_if.byte_position);
          check_field("data_byte", want.data_byte, frame_if.data_byte);
          check_field("has_payload", want.has_payload, frame_if.has_payload);
          check_field("frame_end", want.frame_end, frame_if.frame_end);
        end
      end
      if (holdoff_kick)
        holdoff_left <= HOLDOFF_CYCLES;
      else if (holdoff_left != 0)
        holdoff_left <= holdoff_left - 1;
      frame_if.ready <= !holdoff_kick && holdoff_left == 0 &&
                        ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no handshake on any channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    // register takes the value at this edge
    if (idx == REG_START_MARKER)
      cur_marker = value;
    else
      cur_max_len = value[LEN_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued byte went in and every word came out, then let
  // the output register stage settle before touching registers
  task automatic wait_drained();
    do @(posedge clk);
    while (byte_q.size() != 0 || rx_if.valid || expected_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_header(input logic [BYTE_W-1:0] sub, input logic [BYTE_W-1:0] cmd,
                             input logic [BYTE_W-1:0] tens, input logic [BYTE_W-1:0] units);
    byte_q.push_back(cur_marker);
    byte_q.push_back(sub);
    byte_q.push_back(cmd);
    byte_q.push_back(tens);
    byte_q.push_back(units);
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    // lean a bit toward the marker so it shows up inside frames too
    return ($urandom_range(7, 0) == 0) ? cur_marker : BYTE_W'($urandom_range(255, 0));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_non_digit();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255, 0)); while (is_digit(b));
    return b;
  endfunction

  // Well-formed frame with random header and payload
  task automatic push_frame(input int len);
    push_header(rand_byte(), rand_byte(), DIGIT_ZERO + BYTE_W'(len / 10),
                DIGIT_ZERO + BYTE_W'(len % 10));
    repeat (len) byte_q.push_back(rand_byte());
  endtask

  // Mostly good frames, some noise and broken headers
  task automatic gen_traffic(input int n_bytes);
    int target;
    int sel;
    int eff_max;
    logic [BYTE_W-1:0] b;
    target  = byte_q.size() + n_bytes;
    eff_max = (cur_max_len > 99) ? 99 : int'(cur_max_len);
    while (byte_q.size() < target) begin
      sel = $urandom_range(99, 0);
      if (sel < 8) begin
        // line noise; now and then a stray marker that eats the next frame
        repeat ($urandom_range(4, 1)) begin
          b = BYTE_W'($urandom_range(255, 0));
          if (b == cur_marker && $urandom_range(3, 0) != 0)
            b = ~b;
          byte_q.push_back(b);
        end
      end else if (sel < 14) begin
        push_header(rand_byte(), rand_byte(), rand_non_digit(), rand_byte());
      end else if (sel < 20) begin
        push_header(rand_byte(), rand_byte(), DIGIT_ZERO + BYTE_W'($urandom_range(9, 0)),
                    rand_non_digit());
      end else if (sel < 26 && eff_max < 99) begin
        push_frame($urandom_range(99, eff_max + 1));
      end else if (sel < 32) begin
        push_frame($urandom_range(eff_max, 0));
      end else begin
        push_frame($urandom_range((eff_max < 6) ? eff_max : 6, 0));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] marker_set[NUM_PHASES];
    logic [LEN_W-1:0]  max_set[NUM_PHASES];

    rst              = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_START_MARKER;
    cfg_if.data      = '0;
    holdoff_kick     = 1'b0;
    tx_idle_pct      = 12;
    rx_stall_pct     = 75;
    cur_marker       = '0;
    cur_max_len      = MAX_LEN_RESET;

    // 127 = above 99, every length allowed; 0 = only empty frames pass
    marker_set = '{8'hA5, 8'hFF, 8'h30, 8'h00, 8'h7E, BYTE_W'($urandom_range(255, 0))};
    max_set    = '{7'd127, 7'd0, 7'd12, 7'd99, 7'd1, LEN_W'($urandom_range(127, 0))};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: marker 0x00, max 99
    byte_q.push_back(8'h55);                         // ignored while hunting
    push_header(8'h00, 8'hFF, "0", "0");             // empty frame, sub = marker
    push_header(8'hFF, 8'h00, "0", "1");             // one-byte payload
    byte_q.push_back(8'hFF);
    push_header(8'h12, 8'h34, 8'h00, 8'h00);         // tens is marker value, not a start
    push_header(8'hAA, 8'h55, "9", ":");             // units just past '9'
    push_header(8'h01, 8'h02, "0", "2");
    byte_q.push_back(8'h00);
    byte_q.push_back(8'h80);
    push_header(8'h7F, 8'h80, "/", "0");             // tens just below '0'

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // sender pauses here until the block has delivered everything
      wait_drained();
      if (ph < 2) begin
        tx_idle_pct  <= 12;
        rx_stall_pct <= 75;
      end else if (ph < 4) begin
        tx_idle_pct  <= 75;
        rx_stall_pct <= 12;
      end else begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
      end
      write_reg(REG_START_MARKER, marker_set[ph]);
      write_reg(REG_MAX_LENGTH, {1'b0, max_set[ph]});
      // longest frame there is, accepted since the limit is above 99
      if (ph == 0)
        push_frame(99);
      // frame side shuts for a long while; the output stage fills and
      // rx must back up while bytes keep coming
      if (ph == 4) begin
        @(posedge clk);
        holdoff_kick <= 1'b1;
        @(posedge clk);
        holdoff_kick <= 1'b0;
      end
      gen_traffic(PHASE_BYTES);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: words left over expected 0 actual %0d", $time, expected_words.size());
    end
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- ascii_length_frame_deframer.f -----
rtl/alfd_pkg.sv
rtl/alfd_if.sv
rtl/alfd_parser.sv
rtl/alfd_out_reg.sv
rtl/ascii_length_frame_deframer.sv
tb/ascii_length_frame_deframer_tb.sv
